FILE: hdl/gaussian_3x3_smoother_minmax_unit_assert.svh
// Assertion macros shared by the smoother modules.
`ifndef GAUSSIAN_3X3_SMOOTHER_MINMAX_UNIT_ASSERT_SVH
`define GAUSSIAN_3X3_SMOOTHER_MINMAX_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define GSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define GSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/gsm_pkg.sv
`default_nettype none

package gsm_pkg;

  localparam int GSM_MAX_SIZE = 1024;
  localparam int GSM_COL_W = $clog2(GSM_MAX_SIZE);
  localparam int GSM_SIZE_W = 11;

  localparam int GSM_PIX_W = 8;
  localparam int GSM_CSUM_W = 10;
  localparam int GSM_SUM_W = 12;
  localparam int GSM_RECIP_W = 13;
  localparam int GSM_RECIP_SH = 16;
  localparam int GSM_PROD_W = GSM_SUM_W + GSM_RECIP_W;

  localparam logic GSM_OP_PIXEL = 1'b0;
  localparam logic GSM_OP_FLUSH = 1'b1;

  // floor(x / d) == (x * ceil(2^16 / d)) >> 16 for every x below 4096
  localparam logic [GSM_RECIP_W-1:0] GSM_RECIP_9 = 13'd7282;
  localparam logic [GSM_RECIP_W-1:0] GSM_RECIP_12 = 13'd5462;
  localparam logic [GSM_RECIP_W-1:0] GSM_RECIP_16 = 13'd4096;

  localparam int GSM_FIFO_DEPTH = 4;
  localparam int GSM_FIFO_AW = $clog2(GSM_FIFO_DEPTH);
  localparam int GSM_FIFO_CW = GSM_FIFO_AW + 1;

  localparam int GSM_OUT_W = 32;

  typedef struct packed {
    logic [GSM_PIX_W-1:0] bot;
    logic [GSM_PIX_W-1:0] mid;
    logic [GSM_PIX_W-1:0] top;
  } gsm_col_t;

  typedef struct packed {
    gsm_col_t col;
    logic     emit;
    logic     has_l;
    logic     has_r;
    logic     has_t;
    logic     has_b;
    logic     eor;
    logic     eof;
  } gsm_item_t;

endpackage

`default_nettype wire

FILE: hdl/gaussian_3x3_smoother_minmax_unit.sv
`default_nettype none

// 3x3 Gaussian smoother (1-2-1 by 1-2-1) for square 8-bit images in raster order, with
// border taps masked and the sum divided by the weight in use (9, 12 or 16). Results
// trail the input by one row plus one pixel; after the last pixel, send image_size+1
// flush items (tuser high) to drain the frame. Flushes earlier in the frame are taken
// and ignored; pixels sent during the drain act as flushes. The last result of a frame
// carries tlast together with the frame minimum, maximum and their floored midpoint.
// Unless stalled, one item is taken per clock: the front reads both line buffers once
// per item and the back computes one window per item, each at one per cycle, with a
// four-entry queue between them. A result passes the front register, the queue and
// the back's s1, s2 and output registers. Write image_size only while idle; a write
// restarts the frame. The line buffers need no clearing after reset.
module gaussian_3x3_smoother_minmax_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gsm_pkg::GSM_SIZE_W-1:0]  cfg_wdata,     // image_size
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gsm_pkg::GSM_PIX_W-1:0]   s_axis_tdata,  // [7:0] pixel
  input  logic                            s_axis_tuser,  // [0] op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gsm_pkg::GSM_OUT_W-1:0]   m_axis_tdata,  // smoothed, frame_max, frame_min, threshold
  output logic                            m_axis_tuser,  // [0] end_of_row
  output logic                            m_axis_tlast   // end_of_frame
);
  import gsm_pkg::*;

  logic      f_valid;
  gsm_item_t f_item;
  logic      q_full;
  logic      q_valid;
  gsm_item_t q_item;
  logic      q_pop;

  gsm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (f_valid),
    .item          (f_item),
    .item_ready    (!q_full)
  );

  gsm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid && !q_full),
    .push_item  (f_item),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_item),
    .pop        (q_pop)
  );

  gsm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_we),
    .in_valid      (q_valid),
    .in_item       (q_item),
    .in_pop        (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: hdl/gsm_front.sv
`default_nettype none

`include "gaussian_3x3_smoother_minmax_unit_assert.svh"

module gsm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gsm_pkg::GSM_SIZE_W-1:0]   cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gsm_pkg::GSM_PIX_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,
  output logic                             item_valid,
  output gsm_pkg::gsm_item_t               item,
  input  logic                             item_ready
);
  import gsm_pkg::*;

  logic [GSM_SIZE_W-1:0] image_size;
  logic [GSM_SIZE_W-1:0] s;
  logic [GSM_SIZE_W-1:0] ir;
  logic [GSM_SIZE_W-1:0] ir_next;
  logic [GSM_COL_W-1:0]  ic;
  logic [GSM_COL_W-1:0]  ic_next;
  logic [GSM_COL_W-1:0]  oc;
  logic [GSM_COL_W-1:0]  oc_next;
  logic [GSM_COL_W-1:0]  orow;
  logic [GSM_COL_W-1:0]  orow_next;
  logic [GSM_SIZE_W-1:0] ic_inc;
  logic [GSM_SIZE_W-1:0] oc_inc;
  logic [GSM_SIZE_W-1:0] or_inc;
  logic                  tail;
  logic                  drop;
  logic                  go;
  logic                  emit;
  logic                  has_l;
  logic                  has_r;
  logic                  has_t;
  logic                  has_b;
  logic                  eor;
  logic                  eof;
  logic [GSM_PIX_W-1:0]  px;

  logic                  f_valid;
  logic [GSM_PIX_W-1:0]  f_px;
  logic                  f_emit;
  logic                  f_has_l;
  logic                  f_has_r;
  logic                  f_has_t;
  logic                  f_has_b;
  logic                  f_eor;
  logic                  f_eof;

  logic [GSM_PIX_W-1:0]  older_mem [GSM_MAX_SIZE];
  logic [GSM_PIX_W-1:0]  newer_mem [GSM_MAX_SIZE];
  logic [GSM_PIX_W-1:0]  a_q;
  logic [GSM_PIX_W-1:0]  b_q;
  logic                  wb_pend;
  logic [GSM_COL_W-1:0]  wb_addr;

  always_comb begin
    if (image_size < GSM_SIZE_W'(2)) begin
      s = GSM_SIZE_W'(2);
    end else if (image_size > GSM_SIZE_W'(GSM_MAX_SIZE)) begin
      s = GSM_SIZE_W'(GSM_MAX_SIZE);
    end else begin
      s = image_size;
    end
  end

  assign s_axis_tready = !f_valid || item_ready;

  always_comb begin
    ic_inc = {1'b0, ic} + GSM_SIZE_W'(1);
    oc_inc = {1'b0, oc} + GSM_SIZE_W'(1);
    or_inc = {1'b0, orow} + GSM_SIZE_W'(1);
    tail   = ir >= s;
    drop   = (s_axis_tuser == GSM_OP_FLUSH) && !tail;
    go     = s_axis_tvalid && s_axis_tready && !drop;
    px     = tail ? '0 : s_axis_tdata;
    emit   = (ir >= GSM_SIZE_W'(2)) || ((ir == GSM_SIZE_W'(1)) && (ic != '0));
    has_l  = oc != '0;
    has_r  = (ic != '0) && (oc_inc < s);
    has_t  = orow != '0;
    has_b  = or_inc < s;
    eor    = oc_inc >= s;
    eof    = eor && (or_inc >= s);

    if (ic_inc >= s) begin
      ic_next = '0;
      ir_next = ir + GSM_SIZE_W'(1);
    end else begin
      ic_next = ic_inc[GSM_COL_W-1:0];
      ir_next = ir;
    end
    oc_next   = oc;
    orow_next = orow;
    if (emit) begin
      if (eof) begin
        ic_next   = '0;
        ir_next   = '0;
        oc_next   = '0;
        orow_next = '0;
      end else if (eor) begin
        oc_next   = '0;
        orow_next = or_inc[GSM_COL_W-1:0];
      end else begin
        oc_next   = oc_inc[GSM_COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= GSM_SIZE_W'(GSM_MAX_SIZE);
      ic         <= '0;
      ir         <= '0;
      oc         <= '0;
      orow       <= '0;
      f_valid    <= 1'b0;
      wb_pend    <= 1'b0;
    end else begin
      wb_pend <= go;
      if (cfg_we) begin
        image_size <= cfg_wdata;
        ic         <= '0;
        ir         <= '0;
        oc         <= '0;
        orow       <= '0;
      end else if (go) begin
        ic   <= ic_next;
        ir   <= ir_next;
        oc   <= oc_next;
        orow <= orow_next;
      end
      if (go) begin
        f_valid <= 1'b1;
      end else if (item_ready) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      f_px    <= px;
      f_emit  <= emit;
      f_has_l <= has_l;
      f_has_r <= has_r;
      f_has_t <= has_t;
      f_has_b <= has_b;
      f_eor   <= eor;
      f_eof   <= eof;
      wb_addr <= ic;
    end
  end

  // Older row takes the newer row's old byte in the cycle after the read.
  always_ff @(posedge clk) begin
    if (go) begin
      a_q <= older_mem[ic];
    end
    if (wb_pend) begin
      older_mem[wb_addr] <= b_q;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      b_q           <= newer_mem[ic];
      newer_mem[ic] <= px;
    end
  end

  assign item_valid = f_valid;
  always_comb begin
    item.col.top = a_q;
    item.col.mid = b_q;
    item.col.bot = f_px;
    item.emit    = f_emit;
    item.has_l   = f_has_l;
    item.has_r   = f_has_r;
    item.has_t   = f_has_t;
    item.has_b   = f_has_b;
    item.eor     = f_eor;
    item.eof     = f_eof;
  end

  `GSM_ASSERT_NEXT(a_frame_restart, go && emit && eof, (ic == '0) && (ir == '0) && (oc == '0) && (orow == '0), "frame counters not restarted after last result")

endmodule

`default_nettype wire

FILE: hdl/gsm_fifo.sv
`default_nettype none

`include "gaussian_3x3_smoother_minmax_unit_assert.svh"

module gsm_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gsm_pkg::gsm_item_t push_item,
  output logic               full,
  output logic               head_valid,
  output gsm_pkg::gsm_item_t head_item,
  input  logic               pop
);
  import gsm_pkg::*;

  gsm_item_t              slots [GSM_FIFO_DEPTH];
  logic [GSM_FIFO_AW-1:0] wp;
  logic [GSM_FIFO_AW-1:0] rp;
  logic [GSM_FIFO_CW-1:0] count;

  assign full       = count == GSM_FIFO_CW'(GSM_FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + GSM_FIFO_AW'(1);
      end
      if (pop) begin
        rp <= rp + GSM_FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + GSM_FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - GSM_FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
  end

  `GSM_ASSERT_NOW(a_pop_nonempty, pop, count != '0, "queue read while empty")
  `GSM_ASSERT_NOW(a_push_room, push, count != GSM_FIFO_CW'(GSM_FIFO_DEPTH), "queue written while full")

endmodule

`default_nettype wire

FILE: hdl/gsm_back.sv
`default_nettype none

`include "gaussian_3x3_smoother_minmax_unit_assert.svh"

module gsm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic                            in_valid,
  input  gsm_pkg::gsm_item_t              in_item,
  output logic                            in_pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gsm_pkg::GSM_OUT_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import gsm_pkg::*;

  function automatic logic [GSM_CSUM_W-1:0] col_sum(gsm_col_t c, logic ht, logic hb);
    logic [GSM_CSUM_W-1:0] t;
    logic [GSM_CSUM_W-1:0] b;
    t = ht ? GSM_CSUM_W'(c.top) : '0;
    b = hb ? GSM_CSUM_W'(c.bot) : '0;
    return t + {1'b0, c.mid, 1'b0} + b;
  endfunction

  gsm_col_t              w1;
  gsm_col_t              w2;
  logic [GSM_CSUM_W-1:0] cs_l;
  logic [GSM_CSUM_W-1:0] cs_m;
  logic [GSM_CSUM_W-1:0] cs_r;
  logic [GSM_SUM_W-1:0]  sum;
  logic [GSM_RECIP_W-1:0] recip;

  logic                   s1_valid;
  logic [GSM_SUM_W-1:0]   s1_sum;
  logic [GSM_RECIP_W-1:0] s1_recip;
  logic                   s1_eor;
  logic                   s1_eof;
  logic [GSM_PROD_W-1:0]  prod;

  logic                   s2_valid;
  logic [GSM_PIX_W-1:0]   s2_val;
  logic                   s2_eor;
  logic                   s2_eof;

  logic                   out_valid;
  logic [GSM_PIX_W-1:0]   out_val;
  logic                   out_eor;
  logic                   out_eof;
  logic [GSM_PIX_W-1:0]   out_max;
  logic [GSM_PIX_W-1:0]   out_min;
  logic [GSM_PIX_W-1:0]   out_thr;

  logic [GSM_PIX_W-1:0]   run_max;
  logic [GSM_PIX_W-1:0]   run_min;
  logic [GSM_PIX_W-1:0]   nmax;
  logic [GSM_PIX_W-1:0]   nmin;
  logic [GSM_PIX_W:0]     mm_sum;

  logic out_free;
  logic s2_load;
  logic s1_load;

  assign out_free = !out_valid || m_axis_tready;
  assign s2_load  = !s2_valid || out_free;
  assign s1_load  = !s1_valid || s2_load;
  assign in_pop   = in_valid && s1_load;

  // Window: left = w1, middle = w2, right = incoming column.
  always_comb begin
    cs_l = col_sum(w1, in_item.has_t, in_item.has_b);
    cs_m = col_sum(w2, in_item.has_t, in_item.has_b);
    cs_r = col_sum(in_item.col, in_item.has_t, in_item.has_b);
    sum  = (in_item.has_l ? GSM_SUM_W'(cs_l) : '0) + {1'b0, cs_m, 1'b0}
         + (in_item.has_r ? GSM_SUM_W'(cs_r) : '0);
    if (in_item.has_l && in_item.has_r && in_item.has_t && in_item.has_b) begin
      recip = GSM_RECIP_16;
    end else if ((in_item.has_l != in_item.has_r) && (in_item.has_t != in_item.has_b)) begin
      recip = GSM_RECIP_9;
    end else begin
      recip = GSM_RECIP_12;
    end
  end

  assign prod = GSM_PROD_W'(s1_sum) * GSM_PROD_W'(s1_recip);

  always_comb begin
    nmax   = (s2_val > run_max) ? s2_val : run_max;
    nmin   = (s2_val < run_min) ? s2_val : run_min;
    mm_sum = {1'b0, nmax} + {1'b0, nmin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      run_max   <= '0;
      run_min   <= '1;
    end else begin
      if (s1_load) begin
        s1_valid <= in_pop && in_item.emit;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
      if (restart) begin
        run_max <= '0;
        run_min <= '1;
      end else if (out_free && s2_valid) begin
        if (s2_eof) begin
          run_max <= '0;
          run_min <= '1;
        end else begin
          run_max <= nmax;
          run_min <= nmin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      w1 <= w2;
      w2 <= in_item.col;
    end
    if (s1_load) begin
      s1_sum   <= sum;
      s1_recip <= recip;
      s1_eor   <= in_item.eor;
      s1_eof   <= in_item.eof;
    end
    if (s2_load) begin
      s2_val <= prod[GSM_RECIP_SH +: GSM_PIX_W];
      s2_eor <= s1_eor;
      s2_eof <= s1_eof;
    end
    if (out_free) begin
      out_val <= s2_val;
      out_eor <= s2_eor;
      out_eof <= s2_eof;
      if (s2_eof) begin
        out_max <= nmax;
        out_min <= nmin;
        out_thr <= mm_sum[GSM_PIX_W:1];
      end else begin
        out_max <= '0;
        out_min <= '0;
        out_thr <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_thr, out_min, out_max, out_val};
  assign m_axis_tuser  = out_eor;
  assign m_axis_tlast  = out_eof;

  `GSM_ASSERT_NOW(a_minmax_order, out_valid && out_eof, out_min <= out_max, "frame minimum above maximum")
  `GSM_ASSERT_NOW(a_thr_range, out_valid && out_eof, (out_thr >= out_min) && (out_thr <= out_max), "threshold outside min/max")
  `GSM_ASSERT_NOW(a_stats_zero, out_valid && !out_eof, (out_max == '0) && (out_min == '0) && (out_thr == '0), "frame statistics on a mid-frame result")

endmodule

`default_nettype wire
